// ===== sv/tla_pkg.sv =====
`timescale 1ns / 1ps

package tla_pkg;

  // quotient bits kept by the divider: 2^32 covers the saturation limit
  localparam int QUO_BITS  = 33;
  // root bits of the square root unit, radicand is 2*SQRT_BITS wide
  localparam int SQRT_BITS = 31;

  localparam int LAT_DIV   = QUO_BITS + 3;
  localparam int LAT_SQRT  = SQRT_BITS + 1;
  localparam int LAT_SIDE  = LAT_SQRT + 4;
  localparam int LAT_AREA  = LAT_SQRT + 6;
  // input register, products, determinant subtract
  localparam int LAT_FRONT = 2;

  localparam logic [30:0] MAG_MAX = 31'h7FFFFFFF;

endpackage

// ===== sv/three_line_triangle_area.sv =====
// Three-line triangle solver.
// A request on the line channel (line_valid / line_stall) carries three lines
// a*x + b*y = c in signed fixed point with FRAC_BITS fraction bits. Each pair
// of lines is solved by Cramer's rule, then the three side lengths and the
// Heron area follow. One result leaves on the result channel
// (result_valid / result_stall) for every request.
// Throughput: one request per cycle while no result is stalled.
// The depth is set by the bit-per-stage dividers (33 quotient bits) and the
// two bit-per-stage square root chains.
// A parallel pair sets its parallel_mask bit; its point, the sides using it
// and the area read zero. Coordinates, sides and area saturate.
// Reset clears all valid bits; data registers have no reset.
// When the receiver stalls a valid result, the whole pipeline freezes and
// line_stall rises in the same cycle; nothing is dropped or repeated.
`timescale 1ns / 1ps

module three_line_triangle_area #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,

  input  logic               line_valid,
  output logic               line_stall,
  input  logic signed [31:0] line1_a,
  input  logic signed [31:0] line1_b,
  input  logic signed [31:0] line1_c,
  input  logic signed [31:0] line2_a,
  input  logic signed [31:0] line2_b,
  input  logic signed [31:0] line2_c,
  input  logic signed [31:0] line3_a,
  input  logic signed [31:0] line3_b,
  input  logic signed [31:0] line3_c,

  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [31:0] point12_x,
  output logic signed [31:0] point12_y,
  output logic signed [31:0] point13_x,
  output logic signed [31:0] point13_y,
  output logic signed [31:0] point23_x,
  output logic signed [31:0] point23_y,
  output logic [30:0]        side_12_13,
  output logic [30:0]        side_12_23,
  output logic [30:0]        side_13_23,
  output logic [30:0]        triangle_area,
  output logic [2:0]         parallel_mask
);

  localparam int TOT = tla_pkg::LAT_FRONT + tla_pkg::LAT_DIV
                     + tla_pkg::LAT_SIDE + tla_pkg::LAT_AREA;

  // single enable: everything moves unless a finished result is held back
  logic en;
  assign en         = !(result_valid && result_stall);
  assign line_stall = !en;

  logic [TOT:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TOT-1:0], line_valid};
    end
  end

  assign result_valid = vld[TOT];

  // stage 0: input capture
  logic signed [31:0] ca [0:2];
  logic signed [31:0] cb [0:2];
  logic signed [31:0] cc [0:2];

  always_ff @(posedge clk) begin
    if (en) begin
      ca[0] <= line1_a;  cb[0] <= line1_b;  cc[0] <= line1_c;
      ca[1] <= line2_a;  cb[1] <= line2_b;  cc[1] <= line2_c;
      ca[2] <= line3_a;  cb[2] <= line3_b;  cc[2] <= line3_c;
    end
  end

  // pairs: 0 = lines 1/2, 1 = lines 1/3, 2 = lines 2/3
  logic [2:0]         par;
  logic signed [31:0] qx [0:2];
  logic signed [31:0] qy [0:2];

  for (genvar p = 0; p < 3; p++) begin : g_pair
    localparam int I = (p == 2) ? 1 : 0;
    localparam int J = (p == 0) ? 1 : 2;

    logic signed [63:0] pd0, pd1, px0, px1, py0, py1;
    logic signed [64:0] det, nx, ny;

    // stage 1: cross products
    always_ff @(posedge clk) begin
      if (en) begin
        pd0 <= ca[I] * cb[J];
        pd1 <= ca[J] * cb[I];
        px0 <= cc[I] * cb[J];
        px1 <= cc[J] * cb[I];
        py0 <= ca[I] * cc[J];
        py1 <= ca[J] * cc[I];
      end
    end

    // stage 2: determinant and numerators
    always_ff @(posedge clk) begin
      if (en) begin
        det    <= 65'(pd0) - 65'(pd1);
        nx     <= 65'(px0) - 65'(px1);
        ny     <= 65'(py0) - 65'(py1);
        par[p] <= pd0 == pd1;
      end
    end

    tla_fxdiv #(.FRAC_BITS(FRAC_BITS)) u_div_x (
      .clk (clk),
      .en  (en),
      .num (nx),
      .den (det),
      .quo (qx[p])
    );

    tla_fxdiv #(.FRAC_BITS(FRAC_BITS)) u_div_y (
      .clk (clk),
      .en  (en),
      .num (ny),
      .den (det),
      .quo (qy[p])
    );
  end

  // mask follows the data through divide, side and area sections
  logic [2:0] mask_pt, mask_sd, mask_out;

  tla_delay #(.WIDTH(3), .DEPTH(tla_pkg::LAT_DIV)) u_mask_div (
    .clk (clk), .en (en), .din (par), .dout (mask_pt)
  );

  tla_delay #(.WIDTH(3), .DEPTH(tla_pkg::LAT_SIDE)) u_mask_side (
    .clk (clk), .en (en), .din (mask_pt), .dout (mask_sd)
  );

  tla_delay #(.WIDTH(3), .DEPTH(tla_pkg::LAT_AREA)) u_mask_area (
    .clk (clk), .en (en), .din (mask_sd), .dout (mask_out)
  );

  // parallel pair: point reads zero
  logic signed [31:0] ptx [0:2];
  logic signed [31:0] pty [0:2];

  for (genvar p = 0; p < 3; p++) begin : g_zero
    assign ptx[p] = mask_pt[p] ? 32'sd0 : qx[p];
    assign pty[p] = mask_pt[p] ? 32'sd0 : qy[p];
  end

  logic [30:0] s_a, s_b, s_c, sz_a, sz_b, sz_c;

  tla_side u_side_a (
    .clk (clk), .en (en),
    .x1 (ptx[0]), .y1 (pty[0]), .x2 (ptx[1]), .y2 (pty[1]),
    .side (s_a)
  );

  tla_side u_side_b (
    .clk (clk), .en (en),
    .x1 (ptx[0]), .y1 (pty[0]), .x2 (ptx[2]), .y2 (pty[2]),
    .side (s_b)
  );

  tla_side u_side_c (
    .clk (clk), .en (en),
    .x1 (ptx[1]), .y1 (pty[1]), .x2 (ptx[2]), .y2 (pty[2]),
    .side (s_c)
  );

  // a side touching a parallel pair reads zero
  assign sz_a = (mask_sd[0] || mask_sd[1]) ? 31'd0 : s_a;
  assign sz_b = (mask_sd[0] || mask_sd[2]) ? 31'd0 : s_b;
  assign sz_c = (mask_sd[1] || mask_sd[2]) ? 31'd0 : s_c;

  tla_area #(.FRAC_BITS(FRAC_BITS)) u_area (
    .clk  (clk),
    .en   (en),
    .sa   (sz_a),
    .sb   (sz_b),
    .sc   (sz_c),
    .kill (mask_sd != 3'b000),
    .area (triangle_area)
  );

  tla_delay #(.WIDTH(93), .DEPTH(tla_pkg::LAT_AREA)) u_side_dly (
    .clk  (clk),
    .en   (en),
    .din  ({sz_a, sz_b, sz_c}),
    .dout ({side_12_13, side_12_23, side_13_23})
  );

  tla_delay #(.WIDTH(192), .DEPTH(tla_pkg::LAT_SIDE + tla_pkg::LAT_AREA)) u_pt_dly (
    .clk  (clk),
    .en   (en),
    .din  ({ptx[0], pty[0], ptx[1], pty[1], ptx[2], pty[2]}),
    .dout ({point12_x, point12_y, point13_x, point13_y, point23_x, point23_y})
  );

  assign parallel_mask = mask_out;

endmodule

// ===== sv/tla_delay.sv =====
`timescale 1ns / 1ps

module tla_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] tap [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (en) begin
      tap[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        tap[i] <= tap[i-1];
      end
    end
  end

  assign dout = tap[DEPTH-1];

endmodule

// ===== sv/tla_isqrt.sv =====
`timescale 1ns / 1ps

// Floor square root, one root bit per stage.
module tla_isqrt (
  input  logic                             clk,
  input  logic                             en,
  input  logic [2*tla_pkg::SQRT_BITS-1:0]  rad,
  output logic [tla_pkg::SQRT_BITS-1:0]    root_out
);

  localparam int R   = tla_pkg::SQRT_BITS;
  localparam int RMW = 2 * R + 1;

  logic [RMW-1:0] rem  [0:R-1];
  logic [R-1:0]   root [0:R];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= RMW'(rad);
      root[0] <= '0;
    end
  end

  for (genvar g = 0; g < R; g++) begin : g_step
    localparam int B = R - 1 - g;
    logic [RMW-1:0] trial;
    logic           take;

    // (root + 2^B)^2 - root^2
    assign trial = (RMW'(root[g]) << (B + 1)) | (RMW'(1) << (2 * B));
    assign take  = rem[g] >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        root[g+1] <= take ? (root[g] | (R'(1) << B)) : root[g];
      end
    end

    if (g < R - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem[g+1] <= take ? (rem[g] - trial) : rem[g];
        end
      end
    end
  end

  assign root_out = root[R];

endmodule

// ===== sv/tla_fxdiv.sv =====
`timescale 1ns / 1ps

// Signed fixed-point divide num * 2^FRAC_BITS / den, truncated, saturated to 32 bits.
module tla_fxdiv #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [64:0] num,
  input  logic signed [64:0] den,
  output logic signed [31:0] quo
);

  localparam int QB = tla_pkg::QUO_BITS;
  localparam int RW = (64 + FRAC_BITS > QB + 64) ? 64 + FRAC_BITS : QB + 64;

  logic [63:0]    nm, dm;
  logic           neg_a;

  logic [RW-1:0]  rem   [0:QB-1];
  logic [RW-1:0]  dsh   [0:QB-1];
  logic [QB-1:0]  quo_s [0:QB];
  logic           neg_s [0:QB];
  logic           sat_s [0:QB];

  always_ff @(posedge clk) begin
    if (en) begin
      nm    <= num[64] ? 64'(-num) : num[63:0];
      dm    <= den[64] ? 64'(-den) : den[63:0];
      neg_a <= num[64] ^ den[64];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]   <= RW'(nm) << FRAC_BITS;
      dsh[0]   <= RW'(dm);
      sat_s[0] <= (RW'(nm) << FRAC_BITS) >= (RW'(dm) << QB);
      quo_s[0] <= '0;
      neg_s[0] <= neg_a;
    end
  end

  for (genvar g = 0; g < QB; g++) begin : g_bit
    localparam int B = QB - 1 - g;
    logic [RW-1:0] trial;
    logic          take;

    assign trial = dsh[g] << B;
    assign take  = rem[g] >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        quo_s[g+1] <= take ? (quo_s[g] | (QB'(1) << B)) : quo_s[g];
        neg_s[g+1] <= neg_s[g];
        sat_s[g+1] <= sat_s[g];
      end
    end

    if (g < QB - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem[g+1] <= take ? (rem[g] - trial) : rem[g];
          dsh[g+1] <= dsh[g];
        end
      end
    end
  end

  logic [QB-1:0] lim, qm;

  // negative side reaches one step further
  assign lim = QB'(32'h7FFFFFFF) + QB'(neg_s[QB]);
  assign qm  = (sat_s[QB] || quo_s[QB] > lim) ? lim : quo_s[QB];

  always_ff @(posedge clk) begin
    if (en) begin
      quo <= neg_s[QB] ? -qm[31:0] : qm[31:0];
    end
  end

endmodule

// ===== sv/tla_side.sv =====
`timescale 1ns / 1ps

// Distance between two points, saturated.
module tla_side (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] x1,
  input  logic signed [31:0] y1,
  input  logic signed [31:0] x2,
  input  logic signed [31:0] y2,
  output logic [30:0]        side
);

  logic signed [32:0] dx, dy;
  logic signed [65:0] mx, my;
  logic [63:0]        sqx, sqy;
  logic [64:0]        sum;
  logic [61:0]        rad;
  logic               sat, sat_d;
  logic [30:0]        root;

  assign mx  = dx * dx;
  assign my  = dy * dy;
  assign sum = {1'b0, sqx} + {1'b0, sqy};

  always_ff @(posedge clk) begin
    if (en) begin
      dx  <= 33'(x1) - 33'(x2);
      dy  <= 33'(y1) - 33'(y2);
      sqx <= mx[63:0];
      sqy <= my[63:0];
      rad <= sum[61:0];
      sat <= sum >= (65'(1) << 62);
    end
  end

  tla_isqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .rad      (rad),
    .root_out (root)
  );

  tla_delay #(.WIDTH(1), .DEPTH(tla_pkg::LAT_SQRT)) u_sat_dly (
    .clk  (clk),
    .en   (en),
    .din  (sat),
    .dout (sat_d)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      side <= sat_d ? tla_pkg::MAG_MAX : root;
    end
  end

endmodule

// ===== sv/tla_area.sv =====
`timescale 1ns / 1ps

// Heron area from three sides: sqrt(floor(t0*t1/2^(F+2)) * floor(t2*t3/2^(F+2))).
module tla_area #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        en,
  input  logic [30:0] sa,
  input  logic [30:0] sb,
  input  logic [30:0] sc,
  input  logic        kill,
  output logic [30:0] area
);

  localparam int SH = FRAC_BITS + 2;
  localparam int UW = 65 - SH;
  localparam int WL = (UW + 1) / 2;
  localparam int WH = UW - WL;
  localparam int PW = 2 * UW;

  logic [32:0]        t0;
  logic signed [32:0] t1, t2, t3;
  logic               kill1, ok2, ok3, ok4, ok5, ok_d;
  logic [64:0]        p0;
  logic [63:0]        p1;
  logic [UW-1:0]      u, w, u3;
  logic [WH-1:0]      whi;
  logic [UW+WL-1:0]   mpa, pa, pa4;
  logic [UW+WH-1:0]   mpb, pb;
  logic [PW-1:0]      prod;
  logic [61:0]        rad;
  logic               sat, sat_d;
  logic [30:0]        root;

  assign p0   = t0 * t1[31:0];
  assign p1   = t2[31:0] * t3[31:0];
  assign mpa  = u * w[WL-1:0];
  assign mpb  = u3 * whi;
  assign prod = PW'(pa4) + (PW'(pb) << WL);

  always_ff @(posedge clk) begin
    if (en) begin
      t0    <= 33'(sa) + 33'(sb) + 33'(sc);
      t1    <= 33'(sb) + 33'(sc) - 33'(sa);
      t2    <= 33'(sa) + 33'(sc) - 33'(sb);
      t3    <= 33'(sa) + 33'(sb) - 33'(sc);
      kill1 <= kill;

      // non-positive terms mean a degenerate triangle
      ok2   <= !kill1 && t1 > 33'sd0 && t2 > 33'sd0 && t3 > 33'sd0;
      u     <= UW'(p0 >> SH);
      w     <= UW'(p1 >> SH);

      pa    <= mpa;
      u3    <= u;
      whi   <= w[UW-1:WL];
      ok3   <= ok2;

      pb    <= mpb;
      pa4   <= pa;
      ok4   <= ok3;

      rad   <= prod[61:0];
      sat   <= prod >= (PW'(1) << 62);
      ok5   <= ok4;
    end
  end

  tla_isqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .rad      (rad),
    .root_out (root)
  );

  tla_delay #(.WIDTH(2), .DEPTH(tla_pkg::LAT_SQRT)) u_flag_dly (
    .clk  (clk),
    .en   (en),
    .din  ({ok5, sat}),
    .dout ({ok_d, sat_d})
  );

  always_ff @(posedge clk) begin
    if (en) begin
      area <= !ok_d ? 31'd0 : (sat_d ? tla_pkg::MAG_MAX : root);
    end
  end

endmodule

// ===== bench/three_line_triangle_area_checker.sv =====
`timescale 1ns / 1ps

module three_line_triangle_area_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               line_valid,
  input  logic               line_stall,
  input  logic signed [31:0] line1_a,
  input  logic signed [31:0] line1_b,
  input  logic signed [31:0] line1_c,
  input  logic signed [31:0] line2_a,
  input  logic signed [31:0] line2_b,
  input  logic signed [31:0] line2_c,
  input  logic signed [31:0] line3_a,
  input  logic signed [31:0] line3_b,
  input  logic signed [31:0] line3_c,
  input  logic               result_valid,
  input  logic               result_stall,
  input  logic signed [31:0] point12_x,
  input  logic signed [31:0] point12_y,
  input  logic signed [31:0] point13_x,
  input  logic signed [31:0] point13_y,
  input  logic signed [31:0] point23_x,
  input  logic signed [31:0] point23_y,
  input  logic [30:0]        side_12_13,
  input  logic [30:0]        side_12_23,
  input  logic [30:0]        side_13_23,
  input  logic [30:0]        triangle_area,
  input  logic [2:0]         parallel_mask,
  output int                 fails,
  output int                 pending,
  output int                 triangles_seen
);

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic signed [31:0] px12, py12, px13, py13, px23, py23;
    logic [30:0]        s_a, s_b, s_c, area;
    logic [2:0]         mask;
  } triangle_t;

  localparam wide_t LIM62 = wide_t'(1) <<< 62;

  triangle_t triangle_q[$];

  // n * 2^F / d, toward zero, clipped to 32-bit signed
  function automatic wide_t fixed_quot(wide_t n, wide_t d);
    logic  neg;
    wide_t nm, dm, q, lim;
    neg = (n < 0) != (d < 0);
    nm  = n < 0 ? -n : n;
    dm  = d < 0 ? -d : d;
    q   = (nm <<< FRAC_BITS) / dm;
    lim = neg ? 128'sh8000_0000 : 128'sh7FFF_FFFF;
    if (q > lim) q = lim;
    return neg ? -q : q;
  endfunction

  function automatic wide_t floor_root(wide_t n);
    wide_t res, b;
    res = 0;
    b   = LIM62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n   = n - (res + b);
        res = (res >>> 1) + b;
      end else begin
        res = res >>> 1;
      end
      b = b >>> 2;
    end
    return res;
  endfunction

  function automatic wide_t distance(wide_t x1, wide_t y1, wide_t x2, wide_t y2);
    wide_t sq;
    sq = (x1 - x2) * (x1 - x2) + (y1 - y2) * (y1 - y2);
    return sq >= LIM62 ? 128'sh7FFF_FFFF : floor_root(sq);
  endfunction

  function automatic triangle_t solve_triangle(wide_t v[9]);
    triangle_t r;
    wide_t     px[3], py[3], d, ai, bi, ci, aj, bj, cj;
    wide_t     sa, sb, sc, t0, t1, t2, t3, u, w, area;
    int        i, j, k;
    r = '0;
    for (k = 0; k < 3; k++) begin
      i  = (k == 2) ? 1 : 0;
      j  = (k == 0) ? 1 : 2;
      ai = v[3*i]; bi = v[3*i+1]; ci = v[3*i+2];
      aj = v[3*j]; bj = v[3*j+1]; cj = v[3*j+2];
      d  = ai * bj - aj * bi;
      if (d == 0) begin
        px[k] = 0;
        py[k] = 0;
        r.mask[k] = 1'b1;
      end else begin
        px[k] = fixed_quot(ci * bj - cj * bi, d);
        py[k] = fixed_quot(ai * cj - aj * ci, d);
      end
    end
    sa = (r.mask & 3'b011) != 0 ? 0 : distance(px[0], py[0], px[1], py[1]);
    sb = (r.mask & 3'b101) != 0 ? 0 : distance(px[0], py[0], px[2], py[2]);
    sc = (r.mask & 3'b110) != 0 ? 0 : distance(px[1], py[1], px[2], py[2]);
    area = 0;
    if (r.mask == 0) begin
      t0 = sa + sb + sc; t1 = sb + sc - sa; t2 = sa + sc - sb; t3 = sa + sb - sc;
      // degenerate or rounded-negative radicand reads zero
      if (t1 > 0 && t2 > 0 && t3 > 0) begin
        u = (t0 * t1) >>> (FRAC_BITS + 2);
        w = (t2 * t3) >>> (FRAC_BITS + 2);
        area = (u * w >= LIM62) ? 128'sh7FFF_FFFF : floor_root(u * w);
      end
    end
    r.px12 = px[0][31:0]; r.py12 = py[0][31:0];
    r.px13 = px[1][31:0]; r.py13 = py[1][31:0];
    r.px23 = px[2][31:0]; r.py23 = py[2][31:0];
    r.s_a = sa[30:0]; r.s_b = sb[30:0]; r.s_c = sc[30:0]; r.area = area[30:0];
    return r;
  endfunction

  task automatic compare_field(string name, longint want, longint got);
    if (want != got) begin
      fails++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    wide_t     v[9];
    triangle_t want;
    if (rst) begin
      triangle_q.delete();
    end else begin
      if (line_valid && !line_stall) begin
        v = '{line1_a, line1_b, line1_c, line2_a, line2_b, line2_c,
              line3_a, line3_b, line3_c};
        triangle_q.push_back(solve_triangle(v));
      end
      if (result_valid && !result_stall) begin
        triangles_seen++;
        if (triangle_q.size() == 0) begin
          fails++;
          $display("%0t: result with no request outstanding", $time);
        end else begin
          want = triangle_q.pop_front();
          compare_field("point12_x", want.px12, point12_x);
          compare_field("point12_y", want.py12, point12_y);
          compare_field("point13_x", want.px13, point13_x);
          compare_field("point13_y", want.py13, point13_y);
          compare_field("point23_x", want.px23, point23_x);
          compare_field("point23_y", want.py23, point23_y);
          compare_field("side_12_13", want.s_a, side_12_13);
          compare_field("side_12_23", want.s_b, side_12_23);
          compare_field("side_13_23", want.s_c, side_13_23);
          compare_field("triangle_area", want.area, triangle_area);
          compare_field("parallel_mask", want.mask, parallel_mask);
        end
      end
    end
    pending = triangle_q.size();
  end

  initial begin
    fails = 0;
    pending = 0;
    triangles_seen = 0;
  end

endmodule

// ===== bench/three_line_triangle_area_test.sv =====
`timescale 1ns / 1ps

module three_line_triangle_area_test;

  localparam int ONE          = 32'h0001_0000;  // 1.0 in Q16.16
  localparam int RANDOM_COUNT = 430;
  localparam int WATCHDOG     = 5000;           // cycles with no transfer at all

  logic clk, rst;
  logic line_valid, line_stall, result_valid, result_stall;
  logic signed [31:0] line1_a, line1_b, line1_c, line2_a, line2_b, line2_c;
  logic signed [31:0] line3_a, line3_b, line3_c;
  logic signed [31:0] point12_x, point12_y, point13_x, point13_y, point23_x, point23_y;
  logic [30:0] side_12_13, side_12_23, side_13_23, triangle_area;
  logic [2:0]  parallel_mask;
  int fails, pending, triangles_seen, requests_sent, idle_cycles;
  logic steady;  // no idling on either side while set

  three_line_triangle_area uut (.*);

  three_line_triangle_area_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stalls at random about 13% of cycles, never during steady stretch
  always @(posedge clk)
    result_stall <= !steady && ($urandom_range(99) < 13);

  // watchdog: any accepted request or result resets the count
  always @(posedge clk) begin
    if (rst || (line_valid && !line_stall) || (result_valid && !result_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  // drive one request, hold it through stalls, then maybe leave a gap
  task automatic send_lines(input logic [31:0] a1, b1, c1, a2, b2, c2, a3, b3, c3);
    line_valid <= 1'b1;
    line1_a <= a1; line1_b <= b1; line1_c <= c1;
    line2_a <= a2; line2_b <= b2; line2_c <= c2;
    line3_a <= a3; line3_b <= b3; line3_c <= c3;
    @(posedge clk);
    while (line_stall) @(posedge clk);
    requests_sent++;
    if (!steady && $urandom_range(99) < 15) begin
      line_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // small coefficient in Q16.16: integer part up to +/-range plus random fraction
  function automatic logic [31:0] modest(int range);
    return ($urandom_range(2 * range) - range) * ONE + $urandom_range(ONE - 1);
  endfunction

  initial begin
    int n, kind;
    logic [31:0] a1, b1;
    rst = 1'b1;
    steady = 1'b0;
    line_valid = 1'b0;
    result_stall = 1'b0;
    {line1_a, line1_b, line1_c, line2_a, line2_b, line2_c} = '0;
    {line3_a, line3_b, line3_c} = '0;
    requests_sent = 0;
    idle_cycles = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: right triangle x=0, y=0, x+y=4 (area 8)
    send_lines(ONE, 0, 0, 0, ONE, 0, ONE, ONE, 4 * ONE);
    // all zero: every pair parallel
    send_lines(0, 0, 0, 0, 0, 0, 0, 0, 0);
    // only lines one and two parallel
    send_lines(ONE, ONE, 0, ONE, ONE, ONE, ONE, -ONE, 0);
    // only lines two and three parallel
    send_lines(ONE, 0, 0, 0, ONE, ONE, 0, 2 * ONE, ONE);
    // three lines through one point: zero sides, degenerate area
    send_lines(ONE, 0, ONE, 0, ONE, ONE, ONE, ONE, 2 * ONE);
    // field extremes
    send_lines(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
               32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_lines(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_lines('1, 1, '1, 1, '1, 1, 32'h8000_0000, 1, 32'h7FFF_FFFF);
    // tiny determinants, huge constants: coordinates and sides saturate
    send_lines(1, 0, 32'h7FFF_FFFF, 0, 1, 32'h8000_0000, 1, 1, 32'h7FFF_FFFF);
    send_lines(1, 0, 32'h8000_0000, 0, 1, 32'h8000_0000, 1, -1, 32'h7FFF_FFFF);
    // large triangle: the far corners, the sides and the area saturate
    send_lines(ONE, 0, -20000 * ONE, 0, ONE, -20000 * ONE, ONE, ONE, 20000 * ONE);
    // thin sliver: rounding can leave a non-positive radicand
    send_lines(ONE, 0, 0, ONE, 1, 0, 0, ONE, ONE);
    send_lines(ONE, 1, 3 * ONE, ONE, 2, 3 * ONE + 1, 2 * ONE, 3, 6 * ONE);
    // negative fractional results
    send_lines(3 * ONE, 7 * ONE, -ONE, -5 * ONE, 2 * ONE, ONE, 7, -11, 13);

    // random: mostly proper triangles from modest lines, some full-range noise,
    // some with a copied line direction to force parallel pairs
    for (n = 0; n < RANDOM_COUNT; n++) begin
      steady = (n >= 150 && n < 230);
      kind = $urandom_range(99);
      if (kind < 60) begin
        send_lines(modest(100), modest(100), modest(3000), modest(100), modest(100),
                   modest(3000), modest(100), modest(100), modest(3000));
      end else if (kind < 80) begin
        send_lines($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom);
      end else begin
        a1 = modest(50);
        b1 = modest(50);
        case ($urandom_range(2))
          0: send_lines(a1, b1, modest(500), a1, b1, modest(500),
                        modest(50), modest(50), modest(500));
          1: send_lines(a1, b1, modest(500), modest(50), modest(50), modest(500),
                        -a1, -b1, modest(500));
          default: send_lines(modest(50), modest(50), modest(500), a1, b1,
                              modest(500), a1, b1, $urandom);
        endcase
      end
    end
    line_valid <= 1'b0;
    steady = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);

    $display("Sent %0d line sets: directed corners, parallel pairs, saturation,", requests_sent);
    $display("and random triangles; %0d results checked under random stalls.", triangles_seen);
    if (fails == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/tla_pkg.sv
sv/tla_delay.sv
sv/tla_isqrt.sv
sv/tla_fxdiv.sv
sv/tla_side.sv
sv/tla_area.sv
sv/three_line_triangle_area.sv
bench/three_line_triangle_area_checker.sv
bench/three_line_triangle_area_test.sv
